// ===== rtl/core/unicycle_pose_integrator_assert.svh =====
// Assertion macros shared by the pose integrator RTL.
// Each macro expects clk and rst_n in the scope where it is used.
`ifndef UNICYCLE_POSE_INTEGRATOR_ASSERT_SVH
`define UNICYCLE_POSE_INTEGRATOR_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define UPI_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("upi assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define UPI_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("upi assertion failed");

`endif

// ===== rtl/core/upi_pkg.sv =====
// Package of the unicycle pose integrator: payload types, widths and constants.
// Used by the CORDIC unit and the top level; no dependencies.
package upi_pkg;

  localparam int CORDIC_STAGES = 14;
  localparam int TRIG_W        = 18;
  localparam int ANGLE_W       = 16;
  localparam int Z_W           = 17;
  localparam int STAGE_W       = 4;

  localparam logic signed [TRIG_W-1:0] CORDIC_GAIN_START = 18'sd39797;

  localparam logic REG_STEP_TIME   = 1'b0;
  localparam logic REG_BODY_RADIUS = 1'b1;

  localparam logic [15:0] STEP_TIME_RESET   = 16'd655;
  localparam logic [19:0] BODY_RADIUS_RESET = 20'd3277;

  typedef struct packed {
    logic signed [15:0] speed;
    logic signed [15:0] turn_rate;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic        [15:0] heading;
    logic signed [31:0] front_x;
    logic signed [31:0] front_y;
  } out_item_t;

  typedef struct packed {
    logic signed [TRIG_W-1:0] s;
    logic signed [TRIG_W-1:0] c;
  } sincos_t;

  function automatic logic signed [Z_W-1:0] atan_at(input logic [STAGE_W-1:0] idx);
    logic signed [Z_W-1:0] v;
    unique case (idx)
      4'd0:    v = 17'sd8192;
      4'd1:    v = 17'sd4836;
      4'd2:    v = 17'sd2555;
      4'd3:    v = 17'sd1297;
      4'd4:    v = 17'sd651;
      4'd5:    v = 17'sd326;
      4'd6:    v = 17'sd163;
      4'd7:    v = 17'sd81;
      4'd8:    v = 17'sd41;
      4'd9:    v = 17'sd20;
      4'd10:   v = 17'sd10;
      4'd11:   v = 17'sd5;
      4'd12:   v = 17'sd3;
      4'd13:   v = 17'sd1;
      default: v = 17'sd0;
    endcase
    return v;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
    logic signed [31:0] r;
    if ((v[33:31] == 3'b000) || (v[33:31] == 3'b111)) begin
      r = v[31:0];
    end else if (v[33]) begin
      r = 32'sh8000_0000;
    end else begin
      r = 32'sh7fff_ffff;
    end
    return r;
  endfunction

endpackage

// ===== rtl/core/upi_stream_if.sv =====
// Valid/ready stream interface carrying one payload per transaction.
// The payload type is set per instance from the types in upi_pkg.
interface upi_stream_if #(parameter type payload_t = logic) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/core/upi_cordic.sv =====
// Two-lane iterative rotation-mode CORDIC, one stage per cycle for both lanes.
// Depends on upi_pkg for the arctangent table, widths and result type.
`include "unicycle_pose_integrator_assert.svh"

module upi_cordic (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [15:0]         angle_a,
  input  logic [15:0]         angle_b,
  output logic                done,
  output upi_pkg::sincos_t    res_a,
  output upi_pkg::sincos_t    res_b
);

  localparam logic [upi_pkg::STAGE_W-1:0] LAST_STAGE =
    upi_pkg::STAGE_W'(upi_pkg::CORDIC_STAGES - 1);

  logic                               busy_r;
  logic                               done_r;
  logic [upi_pkg::STAGE_W-1:0]        stage_r;
  logic signed [upi_pkg::TRIG_W-1:0]  x_r    [2];
  logic signed [upi_pkg::TRIG_W-1:0]  y_r    [2];
  logic signed [upi_pkg::Z_W-1:0]     z_r    [2];
  logic                               flip_r [2];

  logic [15:0]                        ang    [2];
  logic                               flip_in[2];
  logic signed [upi_pkg::Z_W-1:0]     z_in   [2];
  logic signed [upi_pkg::TRIG_W-1:0]  x_nxt  [2];
  logic signed [upi_pkg::TRIG_W-1:0]  y_nxt  [2];
  logic signed [upi_pkg::Z_W-1:0]     z_nxt  [2];
  logic signed [upi_pkg::TRIG_W-1:0]  sx     [2];
  logic signed [upi_pkg::TRIG_W-1:0]  sy     [2];
  logic signed [upi_pkg::Z_W-1:0]     atan_v;

  assign ang[0] = angle_a;
  assign ang[1] = angle_b;
  assign atan_v = upi_pkg::atan_at(stage_r);

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      logic [15:0] a;
      flip_in[l] = (ang[l][15:14] == 2'd1) || (ang[l][15:14] == 2'd2);
      a = flip_in[l] ? (ang[l] + 16'h8000) : ang[l];
      z_in[l] = {a[15], a};
      sx[l] = y_r[l] >>> stage_r;
      sy[l] = x_r[l] >>> stage_r;
      if (!z_r[l][upi_pkg::Z_W-1]) begin
        x_nxt[l] = x_r[l] - sx[l];
        y_nxt[l] = y_r[l] + sy[l];
        z_nxt[l] = z_r[l] - atan_v;
      end else begin
        x_nxt[l] = x_r[l] + sx[l];
        y_nxt[l] = y_r[l] - sy[l];
        z_nxt[l] = z_r[l] + atan_v;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      done_r  <= 1'b0;
      stage_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start && !busy_r) begin
        busy_r  <= 1'b1;
        stage_r <= '0;
      end else if (busy_r) begin
        stage_r <= stage_r + 1'b1;
        if (stage_r == LAST_STAGE) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int l = 0; l < 2; l++) begin
      if (start && !busy_r) begin
        x_r[l]    <= upi_pkg::CORDIC_GAIN_START;
        y_r[l]    <= '0;
        z_r[l]    <= z_in[l];
        flip_r[l] <= flip_in[l];
      end else if (busy_r) begin
        x_r[l] <= x_nxt[l];
        y_r[l] <= y_nxt[l];
        z_r[l] <= z_nxt[l];
      end
    end
  end

  assign done    = done_r;
  assign res_a.s = flip_r[0] ? -y_r[0] : y_r[0];
  assign res_a.c = flip_r[0] ? -x_r[0] : x_r[0];
  assign res_b.s = flip_r[1] ? -y_r[1] : y_r[1];
  assign res_b.c = flip_r[1] ? -x_r[1] : x_r[1];

  `UPI_ASSERT_NOW(a_stage_bound, busy_r, stage_r <= LAST_STAGE)
  `UPI_ASSERT_NEXT(a_last_stage_done, busy_r && (stage_r == LAST_STAGE), done_r && !busy_r)
  `UPI_ASSERT_NEXT(a_start_loads, start && !busy_r, busy_r && (stage_r == '0))

endmodule

// ===== rtl/core/unicycle_pose_integrator.sv =====
// Top level of the unicycle pose integrator: sequencer, shared multiplier and pose state.
// Depends on upi_pkg, upi_stream_if and upi_cordic.
//
// Usage: in_ch carries one tick (speed, turn_rate) per transaction; out_ch returns
// one pose (pos_x, pos_y, heading, front_x, front_y) per accepted tick, in order.
// Registers step_time (address 0) and body_radius (address 4) are to be written over
// the APB-style port only while the block is idle; the block itself does not enforce
// this. pready is tied high and reads return values. Each tick runs through a multiply
// for the heading step, a two-lane CORDIC that yields sine and cosine of the old and
// new heading in 14 iterations, and six passes through one shared 35x18 multiplier.
// The sequencer steps through MULH, HEAD, CORD, MUL and DONE, and no new tick is taken
// until the last one has left DONE; in_ch.ready is high only between ticks.
// The result sits in an output register, so the next tick is accepted while it waits;
// if out_ch stalls, the following result is held until the register is free.
// Reset (synchronous, active low) clears the pose to zero and restores the register
// defaults (step_time 655, body_radius 3277).
`include "unicycle_pose_integrator_assert.svh"

module unicycle_pose_integrator (
  input  logic        clk,
  input  logic        rst_n,
  upi_stream_if.sink   in_ch,
  upi_stream_if.source out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MULH = 3'd1;
  localparam logic [2:0] ST_HEAD = 3'd2;
  localparam logic [2:0] ST_CORD = 3'd3;
  localparam logic [2:0] ST_MUL  = 3'd4;
  localparam logic [2:0] ST_DONE = 3'd5;

  localparam logic [2:0] OP_V_SIN  = 3'd0;
  localparam logic [2:0] OP_SIN_DT = 3'd1;
  localparam logic [2:0] OP_V_COS  = 3'd2;
  localparam logic [2:0] OP_COS_DT = 3'd3;
  localparam logic [2:0] OP_R_SIN  = 3'd4;
  localparam logic [2:0] OP_R_COS  = 3'd5;
  localparam logic [2:0] LAST_OP   = 3'd6;

  localparam logic signed [52:0] RND15 = 53'sd1 <<< 14;
  localparam logic signed [52:0] RND16 = 53'sd1 <<< 15;
  localparam logic signed [52:0] RND28 = 53'sd1 <<< 27;

  logic [2:0]          state_r;
  logic [2:0]          op_r;
  logic [15:0]         step_time_r;
  logic [19:0]         body_radius_r;
  logic signed [31:0]  centre_x_r;
  logic signed [31:0]  centre_y_r;
  logic [15:0]         heading_r;
  logic signed [15:0]  speed_r;
  logic signed [15:0]  turn_r;
  logic signed [52:0]  prod_r;
  logic signed [31:0]  front_x_r;
  logic signed [31:0]  front_y_r;
  upi_pkg::out_item_t  out_r;
  logic                out_valid_r;

  logic signed [34:0]  mul_a;
  logic signed [17:0]  mul_b;
  logic signed [52:0]  mul_p;
  logic signed [52:0]  rnd15;
  logic signed [52:0]  rnd16;
  logic signed [52:0]  rnd28;
  logic [15:0]         heading_new;
  logic                in_accept;
  logic                out_free;
  logic                cfg_write;
  logic                cordic_start;
  logic                cordic_done;
  upi_pkg::sincos_t    trig_old;
  upi_pkg::sincos_t    trig_new;

  assign in_ch.ready  = (state_r == ST_IDLE);
  assign in_accept    = in_ch.valid && in_ch.ready;
  assign out_free     = !out_valid_r || out_ch.ready;
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_r;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign prdata    = (paddr[2] == upi_pkg::REG_BODY_RADIUS) ? {12'd0, body_radius_r}
                                                            : {16'd0, step_time_r};

  assign rnd15       = (prod_r + RND15) >>> 15;
  assign rnd16       = (prod_r + RND16) >>> 16;
  assign rnd28       = (prod_r + RND28) >>> 28;
  assign heading_new = heading_r + rnd15[15:0];
  assign cordic_start = (state_r == ST_HEAD);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (state_r == ST_MULH) begin
      mul_a = 35'(turn_r);
      mul_b = {2'b00, step_time_r};
    end else if (state_r == ST_MUL) begin
      unique case (op_r)
        OP_V_SIN: begin
          mul_a = 35'(speed_r);
          mul_b = trig_old.s;
        end
        OP_SIN_DT, OP_COS_DT: begin
          mul_a = prod_r[34:0];
          mul_b = {2'b00, step_time_r};
        end
        OP_V_COS: begin
          mul_a = 35'(speed_r);
          mul_b = trig_old.c;
        end
        OP_R_SIN: begin
          mul_a = {15'd0, body_radius_r};
          mul_b = trig_new.s;
        end
        default: begin
          mul_a = {15'd0, body_radius_r};
          mul_b = trig_new.c;
        end
      endcase
    end
  end

  assign mul_p = 53'(mul_a) * 53'(mul_b);

  upi_cordic u_cordic (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (cordic_start),
    .angle_a (heading_r),
    .angle_b (heading_new),
    .done    (cordic_done),
    .res_a   (trig_old),
    .res_b   (trig_new)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      op_r          <= OP_V_SIN;
      step_time_r   <= upi_pkg::STEP_TIME_RESET;
      body_radius_r <= upi_pkg::BODY_RADIUS_RESET;
      centre_x_r    <= '0;
      centre_y_r    <= '0;
      heading_r     <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_write) begin
        if (paddr[2] == upi_pkg::REG_BODY_RADIUS) begin
          body_radius_r <= pwdata[19:0];
        end else begin
          step_time_r <= pwdata[15:0];
        end
      end
      if ((state_r == ST_DONE) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_accept) begin
            state_r <= ST_MULH;
          end
        end
        ST_MULH: begin
          state_r <= ST_HEAD;
        end
        ST_HEAD: begin
          heading_r <= heading_new;
          state_r   <= ST_CORD;
        end
        ST_CORD: begin
          if (cordic_done) begin
            op_r    <= OP_V_SIN;
            state_r <= ST_MUL;
          end
        end
        ST_MUL: begin
          op_r <= op_r + 1'b1;
          if (op_r == OP_V_COS) begin
            centre_x_r <= upi_pkg::sat32(34'(centre_x_r) + 34'(rnd28));
          end
          if (op_r == OP_R_SIN) begin
            centre_y_r <= upi_pkg::sat32(34'(centre_y_r) + 34'(rnd28));
          end
          if (op_r == LAST_OP) begin
            state_r <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            state_r <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= mul_p;
    if (in_accept) begin
      speed_r <= in_ch.data.speed;
      turn_r  <= in_ch.data.turn_rate;
    end
    if ((state_r == ST_MUL) && (op_r == OP_R_COS)) begin
      front_x_r <= upi_pkg::sat32(34'(centre_x_r) + 34'(rnd16));
    end
    if ((state_r == ST_MUL) && (op_r == LAST_OP)) begin
      front_y_r <= upi_pkg::sat32(34'(centre_y_r) + 34'(rnd16));
    end
    if ((state_r == ST_DONE) && out_free) begin
      out_r.pos_x   <= centre_x_r;
      out_r.pos_y   <= centre_y_r;
      out_r.heading <= heading_r;
      out_r.front_x <= front_x_r;
      out_r.front_y <= front_y_r;
    end
  end

  `UPI_ASSERT_NEXT(a_accept_starts, in_accept, state_r == ST_MULH)
  `UPI_ASSERT_NOW(a_cordic_done_in_wait, cordic_done, state_r == ST_CORD)
  `UPI_ASSERT_NEXT(a_done_holds_on_stall, (state_r == ST_DONE) && !out_free,
                   (state_r == ST_DONE) && out_valid_r)
  `UPI_ASSERT_NOW(a_op_bound, state_r == ST_MUL, op_r <= LAST_OP)

endmodule
